// ===== rtl/core/rts_pkg.sv =====
package rts_pkg;

  // Default depth of one pixel row in the row store.
  localparam int DEF_MAX_WIDTH = 1024;

  // Configuration register widths and reset values.
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_W     = 16;
  localparam int CFG_DATA_W   = 16;
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd16;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd16;

  // Tile geometry: 4x4 pixels, emitted as two planes of 16 words each.
  localparam int TILE_DIM       = 4;
  localparam int WORDS_PER_TILE = 32;
  localparam int WORD_IDX_W     = 5;

  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 4 * CHAN_W;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Row store word layout: red in the low byte, alpha in the high byte.
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

endpackage

// ===== rtl/core/rts_if.sv =====
interface pixel_if import rts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

interface word_if import rts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] high_byte;
  logic [CHAN_W-1:0] low_byte;
  logic              last_of_tile;
  logic              last_of_image;

  modport source (output valid, output high_byte, output low_byte, output last_of_tile,
                  output last_of_image, input ready);
  modport sink   (input valid, input high_byte, input low_byte, input last_of_tile,
                  input last_of_image, output ready);
endinterface

interface cfg_if import rts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rgba8_tile_swizzle.sv =====
// Converts a raster-order RGBA8 pixel stream into a 4x4-tiled RGBA8 texture
// stream. Every accepted pixel is written into a four-row store, and the pixel
// that closes a tile (its last column on its last row, where the image edge
// also closes a tile) starts a burst of 32 sixteen-bit words: 16 alpha/red
// pairs, then 16 green/blue pairs, each in row-major order within the tile.
// Tile positions past the image width or height come out as zeros. Pixels are
// accepted whenever no burst is being read. Once a pixel that closes a tile is
// taken, no new pixel is accepted until every read of its burst is issued, as
// the row store read port delivers one word per cycle while the consumer is
// ready. The word output is registered and keeps streaming one word per cycle
// while the consumer is ready, and the next pixel can be accepted while the
// last words of a burst still wait there. The user must write width and height
// through the configuration port only while the block is idle; the block
// itself does not enforce this. A width of zero counts as one, a width above
// MAX_WIDTH counts as MAX_WIDTH, and a height of zero counts as one. The row
// store is not cleared after reset and needs no start-up time.
module rgba8_tile_swizzle import rts_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic   clk,
  input  logic   rst,
  cfg_if.sink    cfg,
  pixel_if.sink  pixel,
  word_if.source word
);

  localparam int AW  = $clog2(TILE_DIM * MAX_WIDTH);
  localparam int CMW = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
                       $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;

  // Configuration registers, always ready to take a write.
  logic [WIDTH_REG_W-1:0] width_reg;
  logic [HEIGHT_W-1:0]    height_reg;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_IMAGE_WIDTH:  width_reg  <= cfg.data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg <= cfg.data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry. The width saturates at MAX_WIDTH; since MAX_WIDTH may
  // not fit in the width register's bits, the saturated case travels as a flag.
  logic [WIDTH_REG_W-1:0] width_nz;
  logic                   width_full;
  logic [HEIGHT_W-1:0]    eff_height;

  assign width_nz   = (width_reg == '0) ? WIDTH_REG_W'(1) : width_reg;
  assign width_full = CMW'(width_nz) >= CMW'(MAX_WIDTH);
  assign eff_height = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  pixel_t        wr_data, rd_data;

  rts_seq #(.MAX_WIDTH(MAX_WIDTH)) u_seq (
    .clk            (clk),
    .rst            (rst),
    .eff_width_lo   (width_nz),
    .eff_width_full (width_full),
    .eff_height     (eff_height),
    .pixel          (pixel),
    .word           (word),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  rts_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/core/rts_store.sv =====
module rts_store import rts_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(TILE_DIM*MAX_WIDTH)-1:0]  wr_addr,
  input  pixel_t                                 wr_data,
  input  logic                                   rd_en,
  input  logic [$clog2(TILE_DIM*MAX_WIDTH)-1:0]  rd_addr,
  output pixel_t                                 rd_data
);

  localparam int DEPTH = TILE_DIM * MAX_WIDTH;

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued, so a stalled word stays put.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/rts_seq.sv =====
module rts_seq import rts_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [WIDTH_REG_W-1:0]                 eff_width_lo,
  input  logic                                   eff_width_full,
  input  logic [HEIGHT_W-1:0]                    eff_height,
  pixel_if.sink                                  pixel,
  word_if.source                                 word,
  output logic                                   wr_en,
  output logic [$clog2(TILE_DIM*MAX_WIDTH)-1:0]  wr_addr,
  output pixel_t                                 wr_data,
  output logic                                   rd_en,
  output logic [$clog2(TILE_DIM*MAX_WIDTH)-1:0]  rd_addr,
  input  pixel_t                                 rd_data
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int AW  = $clog2(TILE_DIM * MAX_WIDTH);
  localparam int PW  = XW + 1;
  localparam int CMW = (PW > WIDTH_REG_W + 1) ? PW : WIDTH_REG_W + 1;
  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(WORDS_PER_TILE - 1);

  // Effective width as a compare-wide value; "full" means exactly MAX_WIDTH.
  logic [CMW-1:0] w_cmp;
  assign w_cmp = eff_width_full ? CMW'(MAX_WIDTH) : CMW'(eff_width_lo);

  // Raster position counters.
  logic [XW-1:0]       col;
  logic [HEIGHT_W-1:0] row;

  // Tile emission state.
  logic                  emitting;
  logic [WORD_IDX_W-1:0] k;
  logic [XW-1:0]         bx;
  logic [HEIGHT_W-1:0]   by;
  logic                  img_last;

  // Read stage and output register.
  logic s1_v, s1_zero, s1_plane, s1_last_tile, s1_last_img;
  logic out_v;

  logic row_end, img_end, closes, accept, issue, adv;
  logic [1:0]          ix, iy;
  logic [PW-1:0]       px;
  logic [HEIGHT_W:0]   py;
  logic                rd_zero;

  assign accept = pixel.valid && pixel.ready;
  assign pixel.ready = !emitting;

  assign row_end = (CMW'(col) + CMW'(1)) >= w_cmp;
  assign img_end = ({1'b0, row} + 17'd1) >= {1'b0, eff_height};
  assign closes  = ((col[1:0] == 2'd3) || row_end) && ((row[1:0] == 2'd3) || img_end);

  assign wr_en   = accept;
  assign wr_addr = AW'(row[1:0]) * AW'(MAX_WIDTH) + AW'(col);
  assign wr_data = '{alpha: pixel.alpha, blue: pixel.blue, green: pixel.green,
                     red: pixel.red};

  // Pixel position of the word being read; positions off the image read as zero.
  assign ix = k[1:0];
  assign iy = k[3:2];
  assign px = {1'b0, bx} + PW'(ix);
  assign py = {1'b0, by} + 17'(iy);
  assign rd_zero = (CMW'(px) >= w_cmp) || (py >= {1'b0, eff_height}) ||
                   (CMW'(px) >= CMW'(MAX_WIDTH));

  assign adv   = s1_v && (!out_v || word.ready);
  assign issue = emitting && (!s1_v || adv);
  assign rd_en   = issue;
  assign rd_addr = AW'(iy) * AW'(MAX_WIDTH) + AW'(px[XW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      emitting <= 1'b0;
      k        <= '0;
      s1_v     <= 1'b0;
      out_v    <= 1'b0;
    end else begin
      if (accept) begin
        if (row_end) begin
          col <= '0;
          row <= img_end ? '0 : row + 16'd1;
        end else begin
          col <= col + XW'(1);
        end
        if (closes) begin
          emitting <= 1'b1;
          k        <= '0;
        end
      end
      if (issue) begin
        k <= k + WORD_IDX_W'(1);
        if (k == LAST_WORD) begin
          emitting <= 1'b0;
        end
      end
      if (issue) begin
        s1_v <= 1'b1;
      end else if (adv) begin
        s1_v <= 1'b0;
      end
      if (adv) begin
        out_v <= 1'b1;
      end else if (word.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // Tile base and per-word tags; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (accept && closes) begin
      bx       <= col & ~XW'(3);
      by       <= {row[HEIGHT_W-1:2], 2'b00};
      img_last <= row_end && img_end;
    end
    if (issue) begin
      s1_zero      <= rd_zero;
      s1_plane     <= k[4];
      s1_last_tile <= (k == LAST_WORD);
      s1_last_img  <= (k == LAST_WORD) && img_last;
    end
    if (adv) begin
      if (s1_zero) begin
        word.high_byte <= '0;
        word.low_byte  <= '0;
      end else if (s1_plane) begin
        word.high_byte <= rd_data.green;
        word.low_byte  <= rd_data.blue;
      end else begin
        word.high_byte <= rd_data.alpha;
        word.low_byte  <= rd_data.red;
      end
      word.last_of_tile  <= s1_last_tile;
      word.last_of_image <= s1_last_img;
    end
  end

  assign word.valid = out_v;

endmodule
